// ===== hw/rtl/calendar_clock_with_dst_assert.svh =====
// ----------------------------------------------------------------------------
// Calendar clock assertion macros
// Concurrent check wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef CALENDAR_CLOCK_WITH_DST_ASSERT_SVH
`define CALENDAR_CLOCK_WITH_DST_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication
`define CCD_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("calendar clock check failed");
// Next-cycle implication
`define CCD_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("calendar clock check failed");
`else
`define CCD_ASSERT_IMP(label, clk, rst, ante, cons)
`define CCD_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hw/rtl/ccd_pkg.sv =====
// ----------------------------------------------------------------------------
// Calendar clock package
// Field widths, register codes, reset values, state types and calendar
// helper functions shared by the calendar clock modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ccd_pkg;

  // Field widths
  localparam int unsigned YEAR_W      = 16;
  localparam int unsigned MONTH_W     = 4;
  localparam int unsigned DAY_W       = 5;
  localparam int unsigned HOUR_W      = 5;
  localparam int unsigned MINUTE_W    = 6;
  localparam int unsigned WEEKDAY_W   = 3;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_START_YEAR    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_START_MONTH   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_START_DAY     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_START_HOUR    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_START_MINUTE  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_START_WEEKDAY = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_START_DST     = 3'd6;

  // Calendar limits, on the widened working values of the update
  localparam logic [6:0] MINUTE_WRAP  = 7'd60;
  localparam logic [5:0] HOUR_WRAP    = 6'd24;
  localparam logic [3:0] WEEKDAY_WRAP = 4'd8;
  localparam logic [3:0] SUNDAY       = 4'd7;
  localparam logic [4:0] MONTH_WRAP   = 5'd13;
  localparam logic [4:0] MARCH        = 5'd3;
  localparam logic [4:0] OCTOBER      = 5'd10;
  localparam logic [5:0] DST_DAY_MIN  = 6'd25;
  localparam logic [5:0] DST_HOUR_STD = 6'd1;
  localparam logic [5:0] DST_HOUR_SUM = 6'd2;
  localparam logic [6:0] CENTURY_LAST = 7'd99;

  // Year split: floor(y / 100) estimated as (y * RECIP) >> RECIP_SHIFT
  localparam logic [15:0] RECIP       = 16'd41943;
  localparam int unsigned RECIP_SHIFT = 22;
  localparam logic [15:0] CENTURY     = 16'd100;

  // Visible calendar time
  typedef struct packed {
    logic [YEAR_W-1:0]    year;
    logic [MONTH_W-1:0]   month;
    logic [DAY_W-1:0]     day;
    logic [HOUR_W-1:0]    hour;
    logic [MINUTE_W-1:0]  minute;
    logic [WEEKDAY_W-1:0] weekday;
    logic                 dst;
  } cal_time_t;

  // Year residues: year mod 100 and (year div 100) mod 4
  typedef struct packed {
    logic [6:0] mod100;
    logic [1:0] cent;
  } year_res_t;

  typedef struct packed {
    cal_time_t t;
    year_res_t res;
  } clock_state_t;

  localparam cal_time_t START_RST = '{
    year:    16'd2000,
    month:   4'd1,
    day:     5'd1,
    hour:    5'd0,
    minute:  6'd0,
    weekday: 3'd6,
    dst:     1'b0
  };

  // 2000 mod 100 is 0, 20 mod 4 is 0
  localparam year_res_t RES_RST = '{mod100: 7'd0, cent: 2'd0};

  // Gregorian leap rule from the year residues (year 0 is leap)
  function automatic logic is_leap(input logic [1:0] year_low, input year_res_t res);
    is_leap = ((res.mod100 != 7'd0) && (year_low == 2'd0)) ||
              ((res.mod100 == 7'd0) && (res.cent == 2'd0));
  endfunction

  // Days in a month; out-of-range months count as 31
  function automatic logic [4:0] month_len(input logic [MONTH_W-1:0] m, input logic leap);
    unique case (m)
      4'd2:                    month_len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: month_len = 5'd30;
      default:                 month_len = 5'd31;
    endcase
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ccd_if.sv =====
// ----------------------------------------------------------------------------
// Calendar clock channels
// Valid/ready channels for the tick beats and the calendar result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface ccd_tick_if;
  logic valid;
  logic ready;
  logic tick;

  modport source (output valid, output tick, input ready);
  modport sink   (input valid, input tick, output ready);
endinterface

interface ccd_time_if;
  import ccd_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [YEAR_W-1:0]    year;
  logic [MONTH_W-1:0]   month;
  logic [DAY_W-1:0]     day;
  logic [HOUR_W-1:0]    hour;
  logic [MINUTE_W-1:0]  minute;
  logic [WEEKDAY_W-1:0] weekday;
  logic                 in_dst;
  logic                 leap;

  modport source (output valid, output year, output month, output day, output hour,
                  output minute, output weekday, output in_dst, output leap,
                  input ready);
  modport sink   (input valid, input year, input month, input day, input hour,
                  input minute, input weekday, input in_dst, input leap,
                  output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ccd_year_split.sv =====
// ----------------------------------------------------------------------------
// Calendar clock year split
// Splits a loaded year into year mod 100 and century mod 4 using a
// reciprocal multiply and one correcting subtract.
// ----------------------------------------------------------------------------
`default_nettype none

module ccd_year_split (
  input  logic [ccd_pkg::YEAR_W-1:0] year,
  output ccd_pkg::year_res_t         res
);
  import ccd_pkg::*;

  logic [31:0] prod;
  logic [9:0]  q_est;
  logic [15:0] rem_est;
  logic [9:0]  q;

  // Estimate the quotient from below: exact or one short
  assign prod    = 32'(year) * 32'(RECIP);
  assign q_est   = prod[31:RECIP_SHIFT];
  assign rem_est = year - 16'({6'd0, q_est} * CENTURY);

  // Correct once where the remainder reached a full century
  always_comb begin
    if (rem_est >= CENTURY) begin
      res.mod100 = 7'(rem_est - CENTURY);
      q          = q_est + 10'd1;
    end else begin
      res.mod100 = 7'(rem_est);
      q          = q_est;
    end
    res.cent = q[1:0];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ccd_advance.sv =====
// ----------------------------------------------------------------------------
// Calendar clock advance
// Next state for one tick beat: minute step, hour, weekday, day, month and
// year carries, then the daylight saving start and end rules.
// ----------------------------------------------------------------------------
`default_nettype none

module ccd_advance (
  input  logic                  tick,
  input  ccd_pkg::clock_state_t cur,
  output ccd_pkg::clock_state_t nxt
);
  import ccd_pkg::*;

  always_comb begin
    logic [6:0]  mi;
    logic [5:0]  hr;
    logic [5:0]  dy;
    logic [3:0]  wd;
    logic [4:0]  mo;
    logic [15:0] yr;
    year_res_t   res;
    logic        dst;

    mi  = {1'b0, cur.t.minute} + 7'd1;
    hr  = {1'b0, cur.t.hour};
    dy  = {1'b0, cur.t.day};
    wd  = {1'b0, cur.t.weekday};
    mo  = {1'b0, cur.t.month};
    yr  = cur.t.year;
    res = cur.res;
    dst = cur.t.dst;

    // Carry minute into hour, hour into day and weekday
    if (mi >= MINUTE_WRAP) begin
      mi = 7'd0;
      hr = hr + 6'd1;
    end
    if (hr >= HOUR_WRAP) begin
      hr = 6'd0;
      dy = dy + 6'd1;
      wd = wd + 4'd1;
    end
    if (wd >= WEEKDAY_WRAP) begin
      wd = 4'd1;
    end

    // Wrap the day at the month length of the current year
    if (dy > {1'b0, month_len(cur.t.month, is_leap(cur.t.year[1:0], cur.res))}) begin
      dy = 6'd1;
      mo = mo + 5'd1;
    end

    // Carry into the year and keep its residues in step
    if (mo >= MONTH_WRAP) begin
      mo = 5'd1;
      yr = yr + 16'd1;
      if (cur.t.year == '1) begin
        res = '0;
      end else if (res.mod100 == CENTURY_LAST) begin
        res.mod100 = 7'd0;
        res.cent   = res.cent + 2'd1;
      end else begin
        res.mod100 = res.mod100 + 7'd1;
      end
    end

    // Enter summer time on a late March Sunday
    if (mo == MARCH && dy >= DST_DAY_MIN && hr == DST_HOUR_STD && wd == SUNDAY) begin
      hr  = DST_HOUR_SUM;
      dst = 1'b1;
    end
    // Leave summer time on a late October Sunday
    if (mo == OCTOBER && dy >= DST_DAY_MIN && hr == DST_HOUR_SUM && wd == SUNDAY && dst) begin
      hr  = DST_HOUR_STD;
      dst = 1'b0;
    end

    // Hold the state on a zero tick
    if (tick) begin
      nxt.t.year    = yr;
      nxt.t.month   = mo[MONTH_W-1:0];
      nxt.t.day     = dy[DAY_W-1:0];
      nxt.t.hour    = hr[HOUR_W-1:0];
      nxt.t.minute  = mi[MINUTE_W-1:0];
      nxt.t.weekday = wd[WEEKDAY_W-1:0];
      nxt.t.dst     = dst;
      nxt.res       = res;
    end else begin
      nxt = cur;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/calendar_clock_with_dst.sv =====
// A tick beat's result is captured in the result register when the beat is accepted.
// Throughput: one tick beat per cycle while the sink is ready; the result register frees itself as it drains.
// The clock state register updates on the accepting edge, so beats chain without gaps.
// Reset (synchronous, rst high): start registers take their defaults, 2000-01-01 00:00,
// Saturday, standard time, and the clock state loads from them; no result is pending.
// A valid start register write reloads the whole clock state at the edge that takes it.
// ----------------------------------------------------------------------------
// Calendar clock with daylight saving, top level
// Minute-tick calendar with Gregorian leap years and summer time switching,
// loadable through a start register write port.
// ----------------------------------------------------------------------------
`default_nettype none
`include "calendar_clock_with_dst_assert.svh"

module calendar_clock_with_dst (
  input  logic                             clk,
  input  logic                             rst,
  ccd_tick_if.sink                         tick_ch,
  ccd_time_if.source                       time_ch,
  input  logic                             cfg_we,
  input  logic [ccd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [ccd_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import ccd_pkg::*;

  cal_time_t    start;
  cal_time_t    start_next;
  year_res_t    start_res;
  clock_state_t state;
  clock_state_t state_adv;
  logic         cfg_hit;
  logic         accept;
  logic         res_valid;
  cal_time_t    res;
  logic         res_leap;

  // Merge a register write into the start values
  always_comb begin
    start_next = start;
    cfg_hit    = 1'b0;
    if (cfg_we) begin
      cfg_hit = 1'b1;
      unique case (cfg_index)
        CFG_START_YEAR:    start_next.year    = cfg_data;
        CFG_START_MONTH:   start_next.month   = cfg_data[MONTH_W-1:0];
        CFG_START_DAY:     start_next.day     = cfg_data[DAY_W-1:0];
        CFG_START_HOUR:    start_next.hour    = cfg_data[HOUR_W-1:0];
        CFG_START_MINUTE:  start_next.minute  = cfg_data[MINUTE_W-1:0];
        CFG_START_WEEKDAY: start_next.weekday = cfg_data[WEEKDAY_W-1:0];
        CFG_START_DST:     start_next.dst     = cfg_data[0];
        default:           cfg_hit            = 1'b0;
      endcase
    end
  end

  // Split the year being loaded into its leap residues
  ccd_year_split u_year_split (
    .year (start_next.year),
    .res  (start_res)
  );

  // Next state for the incoming beat
  ccd_advance u_advance (
    .tick (tick_ch.tick),
    .cur  (state),
    .nxt  (state_adv)
  );

  // Take a beat whenever the result register is empty or draining
  assign tick_ch.ready = !res_valid || time_ch.ready;
  assign accept        = tick_ch.valid && tick_ch.ready;

  // Hold start registers, clock state and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      start     <= START_RST;
      state     <= '{t: START_RST, res: RES_RST};
      res_valid <= 1'b0;
    end else begin
      if (cfg_hit) begin
        start <= start_next;
        state <= '{t: start_next, res: start_res};
      end else if (accept) begin
        state <= state_adv;
      end
      if (accept) begin
        res_valid <= 1'b1;
      end else if (time_ch.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Capture the result beat
  always_ff @(posedge clk) begin
    if (accept) begin
      res      <= state_adv.t;
      res_leap <= is_leap(state_adv.t.year[1:0], state_adv.res);
    end
  end

  assign time_ch.valid   = res_valid;
  assign time_ch.year    = res.year;
  assign time_ch.month   = res.month;
  assign time_ch.day     = res.day;
  assign time_ch.hour    = res.hour;
  assign time_ch.minute  = res.minute;
  assign time_ch.weekday = res.weekday;
  assign time_ch.in_dst  = res.dst;
  assign time_ch.leap    = res_leap;

  // Checks
  `CCD_ASSERT_NXT(a_minute_in_range, clk, rst, accept && tick_ch.tick, time_ch.minute < 6'd60)
  `CCD_ASSERT_NXT(a_zero_tick_holds, clk, rst, accept && !tick_ch.tick && !cfg_hit, state == $past(state))
  `CCD_ASSERT_NXT(a_beat_registered, clk, rst, accept, time_ch.valid)
  `CCD_ASSERT_IMP(a_stall_only_full, clk, rst, !tick_ch.ready, res_valid && !time_ch.ready)

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar clock with daylight saving, testbench
// Offers minute tick beats over the tick channel and loads start times
// through the register port. A local calendar model predicts each result
// beat, and the result channel is checked field by field. Directed tests
// cover reset, field extremes, leap years and summer time. They are followed
// by random runs, mostly started near calendar boundaries, and a long sink hold-off.
// ----------------------------------------------------------------------------

module tb;

  localparam logic [ccd_pkg::CFG_INDEX_W-1:0] CFG_UNUSED = 3'd7;
  localparam int unsigned RANDOM_BEATS = 1600;
  localparam int unsigned LIMIT_CYCLES = 300000;
  localparam int unsigned REPORT_LIMIT = 40;

  typedef struct packed {
    logic [ccd_pkg::YEAR_W-1:0]    year;
    logic [ccd_pkg::MONTH_W-1:0]   month;
    logic [ccd_pkg::DAY_W-1:0]     day;
    logic [ccd_pkg::HOUR_W-1:0]    hour;
    logic [ccd_pkg::MINUTE_W-1:0]  minute;
    logic [ccd_pkg::WEEKDAY_W-1:0] weekday;
    logic                          in_dst;
    logic                          leap;
  } time_beat_t;

  typedef enum int unsigned {
    START_MONTH_END, START_YEAR_END, START_LEAP_DAY, START_SUMMER_ON,
    START_SUMMER_OFF, START_ANY_BITS, START_ONE_REG
  } start_kind_t;

  typedef enum int unsigned {
    SINK_OPEN, SINK_COIN, SINK_MOSTLY_OPEN, SINK_MOSTLY_SHUT, SINK_EVERY_THIRD
  } sink_mode_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [ccd_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [ccd_pkg::CFG_DATA_W-1:0]  cfg_data;

  ccd_tick_if tick_ch ();
  ccd_time_if time_ch ();

  calendar_clock_with_dst dut (
    .clk       (clk),
    .rst       (rst),
    .tick_ch   (tick_ch),
    .time_ch   (time_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Calendar model state and expected result beats
  ccd_pkg::cal_time_t start_regs;
  ccd_pkg::cal_time_t wall_now;
  time_beat_t         expected_times[$];
  int unsigned        mismatch_count = 0;

  // Sender and sink controls
  int unsigned burst_left = 0;
  bit          sender_gappy = 1'b1;
  bit          hold_request = 1'b0;
  int unsigned hold_len = 0;
  bit          sink_holding = 1'b0;

  // --------------------------------------------------------------------------
  // Calendar model
  // --------------------------------------------------------------------------
  function automatic bit leap_year(input int unsigned y);
    return ((y % 4) == 0 && (y % 100) != 0) || ((y % 400) == 0);
  endfunction

  function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
    case (m)
      2:           return leap_year(y) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  // Advance one minute, then apply the summer time switches
  function automatic void advance_wall_clock();
    int unsigned mi, hr, dy, wd, mo, yr;
    mi = int'(wall_now.minute) + 1;
    hr = int'(wall_now.hour);
    dy = int'(wall_now.day);
    wd = int'(wall_now.weekday);
    mo = int'(wall_now.month);
    yr = int'(wall_now.year);
    if (mi >= 60) begin
      mi = 0;
      hr++;
    end
    if (hr >= 24) begin
      hr = 0;
      dy++;
      wd++;
    end
    if (wd >= 8) wd = 1;
    if (dy > days_in_month(mo, yr)) begin
      dy = 1;
      mo++;
    end
    if (mo >= 13) begin
      mo = 1;
      yr = (yr + 1) & 32'hFFFF;
    end
    if (mo == 3 && dy >= 25 && hr == 1 && wd == 7) begin
      hr = 2;
      wall_now.dst = 1'b1;
    end
    if (mo == 10 && dy >= 25 && hr == 2 && wd == 7 && wall_now.dst) begin
      hr = 1;
      wall_now.dst = 1'b0;
    end
    wall_now.minute  = mi[ccd_pkg::MINUTE_W-1:0];
    wall_now.hour    = hr[ccd_pkg::HOUR_W-1:0];
    wall_now.day     = dy[ccd_pkg::DAY_W-1:0];
    wall_now.weekday = wd[ccd_pkg::WEEKDAY_W-1:0];
    wall_now.month   = mo[ccd_pkg::MONTH_W-1:0];
    wall_now.year    = yr[ccd_pkg::YEAR_W-1:0];
  endfunction

  function automatic time_beat_t current_beat();
    time_beat_t b;
    b.year    = wall_now.year;
    b.month   = wall_now.month;
    b.day     = wall_now.day;
    b.hour    = wall_now.hour;
    b.minute  = wall_now.minute;
    b.weekday = wall_now.weekday;
    b.in_dst  = wall_now.dst;
    b.leap    = leap_year(int'(wall_now.year));
    return b;
  endfunction

  // Any valid start register write reloads the whole clock
  function automatic void note_start_write(input logic [ccd_pkg::CFG_INDEX_W-1:0] idx,
                                           input logic [ccd_pkg::CFG_DATA_W-1:0] data);
    bit reload;
    reload = 1'b1;
    case (idx)
      ccd_pkg::CFG_START_YEAR:    start_regs.year    = data[ccd_pkg::YEAR_W-1:0];
      ccd_pkg::CFG_START_MONTH:   start_regs.month   = data[ccd_pkg::MONTH_W-1:0];
      ccd_pkg::CFG_START_DAY:     start_regs.day     = data[ccd_pkg::DAY_W-1:0];
      ccd_pkg::CFG_START_HOUR:    start_regs.hour    = data[ccd_pkg::HOUR_W-1:0];
      ccd_pkg::CFG_START_MINUTE:  start_regs.minute  = data[ccd_pkg::MINUTE_W-1:0];
      ccd_pkg::CFG_START_WEEKDAY: start_regs.weekday = data[ccd_pkg::WEEKDAY_W-1:0];
      ccd_pkg::CFG_START_DST:     start_regs.dst     = data[0];
      default:                    reload = 1'b0;
    endcase
    if (reload) wall_now = start_regs;
  endfunction

  function automatic ccd_pkg::cal_time_t make_time(input int unsigned y, input int unsigned mo,
                                                   input int unsigned d, input int unsigned h,
                                                   input int unsigned mi, input int unsigned wd,
                                                   input bit dst);
    ccd_pkg::cal_time_t t;
    t.year    = y[ccd_pkg::YEAR_W-1:0];
    t.month   = mo[ccd_pkg::MONTH_W-1:0];
    t.day     = d[ccd_pkg::DAY_W-1:0];
    t.hour    = h[ccd_pkg::HOUR_W-1:0];
    t.minute  = mi[ccd_pkg::MINUTE_W-1:0];
    t.weekday = wd[ccd_pkg::WEEKDAY_W-1:0];
    t.dst     = dst;
    return t;
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // Offer one tick beat, record its expected result at the accepting edge
  task automatic send_tick(input logic t);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = sender_gappy ? $urandom_range(0, 5) : 0;
      if (gap != 0) begin
        tick_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    tick_ch.valid <= 1'b1;
    tick_ch.tick  <= t;
    do @(posedge clk); while (tick_ch.ready !== 1'b1);
    if (t) advance_wall_clock();
    expected_times.push_back(current_beat());
  endtask

  // Drop valid and wait until every expected beat has come back
  task automatic drain_results();
    tick_ch.valid <= 1'b0;
    burst_left = 0;
    while (expected_times.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Callers lower the write enable after the last write of a series
  task automatic cfg_write(input logic [ccd_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [ccd_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    note_start_write(idx, data);
  endtask

  // Write all seven start registers; upper carries the bits above each field
  task automatic load_clock(input ccd_pkg::cal_time_t t, input logic [15:0] upper);
    cfg_write(ccd_pkg::CFG_START_YEAR, t.year);
    cfg_write(ccd_pkg::CFG_START_MONTH, {upper[15:ccd_pkg::MONTH_W], t.month});
    cfg_write(ccd_pkg::CFG_START_DAY, {upper[15:ccd_pkg::DAY_W], t.day});
    cfg_write(ccd_pkg::CFG_START_HOUR, {upper[15:ccd_pkg::HOUR_W], t.hour});
    cfg_write(ccd_pkg::CFG_START_MINUTE, {upper[15:ccd_pkg::MINUTE_W], t.minute});
    cfg_write(ccd_pkg::CFG_START_WEEKDAY, {upper[15:ccd_pkg::WEEKDAY_W], t.weekday});
    cfg_write(ccd_pkg::CFG_START_DST, {upper[15:1], t.dst});
    cfg_we <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Result sink: stall pattern of its own, long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : result_sink
    sink_mode_t  mode;
    int unsigned mode_left;
    int unsigned hold_left;
    int unsigned phase;
    mode = SINK_OPEN;
    mode_left = 0;
    hold_left = 0;
    phase = 0;
    time_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_left = hold_len;
        hold_request = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        sink_holding = 1'b1;
        time_ch.ready <= 1'b0;
      end else begin
        sink_holding = 1'b0;
        if (mode_left == 0) begin
          mode = sink_mode_t'($urandom_range(0, 4));
          mode_left = $urandom_range(16, 200);
        end
        mode_left--;
        phase++;
        case (mode)
          SINK_OPEN:        time_ch.ready <= 1'b1;
          SINK_COIN:        time_ch.ready <= 1'($urandom_range(0, 1));
          SINK_MOSTLY_OPEN: time_ch.ready <= ($urandom_range(0, 3) != 0);
          SINK_MOSTLY_SHUT: time_ch.ready <= ($urandom_range(0, 3) == 0);
          default:          time_ch.ready <= ((phase % 3) != 0);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checker
  // --------------------------------------------------------------------------
  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
        $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    time_beat_t want;
    if (!rst && time_ch.valid === 1'b1 && time_ch.ready === 1'b1) begin
      if (expected_times.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("%0t ns: result beat with nothing expected, expected none, got year %0d",
                   $time, time_ch.year);
      end else begin
        want = expected_times.pop_front();
        compare_field("year", want.year, time_ch.year);
        compare_field("month", 16'(want.month), 16'(time_ch.month));
        compare_field("day", 16'(want.day), 16'(time_ch.day));
        compare_field("hour", 16'(want.hour), 16'(time_ch.hour));
        compare_field("minute", 16'(want.minute), 16'(time_ch.minute));
        compare_field("weekday", 16'(want.weekday), 16'(time_ch.weekday));
        compare_field("in_dst", 16'(want.in_dst), 16'(time_ch.in_dst));
        compare_field("leap", 16'(want.leap), 16'(time_ch.leap));
      end
    end
  end

  // Give up on a hung run
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_reset_values();
    send_tick(1'b0);
    send_tick(1'b1);
    drain_results();
  endtask

  task automatic test_field_extremes();
    // every field at all ones, past every wrap at once
    load_clock('1, 16'hFFFF);
    send_tick(1'b0);
    send_tick(1'b1);
    drain_results();
    // every field at zero
    load_clock('0, 16'h0000);
    send_tick(1'b1);
    send_tick(1'b0);
    drain_results();
    // unused register index must not reload
    cfg_write(CFG_UNUSED, 16'hA5A5);
    cfg_we <= 1'b0;
    send_tick(1'b1);
    drain_results();
    // last minute of the last year, in summer time
    load_clock(make_time(65535, 12, 31, 23, 59, 7, 1'b1), 16'h0000);
    send_tick(1'b1);
    drain_results();
  endtask

  task automatic test_leap_years();
    load_clock(make_time(2100, 2, 28, 23, 59, 1, 1'b0), 16'h0000);
    send_tick(1'b1);
    drain_results();
    load_clock(make_time(2000, 2, 29, 23, 59, 2, 1'b0), 16'h0000);
    send_tick(1'b1);
    drain_results();
    load_clock(make_time(2024, 2, 28, 23, 59, 3, 1'b0), 16'h0000);
    send_tick(1'b1);
    drain_results();
    load_clock(make_time(0, 2, 28, 23, 59, 4, 1'b0), 16'h0000);
    send_tick(1'b1);
    drain_results();
  endtask

  task automatic test_summer_time();
    // spring forward at 01:00 on a late March Sunday
    load_clock(make_time(2024, 3, 31, 0, 59, 7, 1'b0), 16'h0000);
    send_tick(1'b1);
    send_tick(1'b1);
    drain_results();
    // fall back at 02:00 on a late October Sunday while in summer time
    load_clock(make_time(2024, 10, 27, 1, 59, 7, 1'b1), 16'h0000);
    send_tick(1'b1);
    drain_results();
    // no fall back with the flag already clear
    load_clock(make_time(2024, 10, 25, 1, 59, 7, 1'b0), 16'h0000);
    send_tick(1'b1);
    drain_results();
  endtask

  function automatic int unsigned pick_year();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return 65535;
      2:       return 1900;
      3:       return 2000;
      4:       return 2100;
      5:       return 2024;
      6:       return 2023;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  // Start point near a boundary of the given kind, or all random bits
  function automatic ccd_pkg::cal_time_t pick_start(input start_kind_t kind);
    ccd_pkg::cal_time_t t;
    int unsigned y, mo;
    y  = pick_year();
    mo = $urandom_range(1, 12);
    t  = make_time(y, mo, $urandom_range(1, days_in_month(mo, y)), $urandom_range(0, 23),
                   $urandom_range(0, 59), $urandom_range(1, 7), 1'($urandom_range(0, 1)));
    case (kind)
      START_MONTH_END: begin
        t.day    = 5'(days_in_month(mo, y));
        t.hour   = 5'd23;
        t.minute = 6'($urandom_range(20, 59));
      end
      START_YEAR_END: begin
        t.month  = 4'd12;
        t.day    = 5'd31;
        t.hour   = 5'd23;
        t.minute = 6'($urandom_range(20, 59));
      end
      START_LEAP_DAY: begin
        t.month  = 4'd2;
        t.day    = 5'($urandom_range(28, 29));
        t.hour   = 5'd23;
        t.minute = 6'($urandom_range(20, 59));
      end
      START_SUMMER_ON: begin
        t.month = 4'd3;
        if ($urandom_range(0, 2) == 0) begin
          // Saturday night into a qualifying Sunday
          t.day     = 5'($urandom_range(24, 30));
          t.weekday = 3'd6;
          t.hour    = 5'd23;
          t.minute  = 6'($urandom_range(50, 59));
        end else begin
          t.day     = 5'($urandom_range(25, 31));
          t.weekday = 3'd7;
          t.hour    = 5'd0;
          t.minute  = 6'($urandom_range(10, 59));
        end
      end
      START_SUMMER_OFF: begin
        t.month   = 4'd10;
        t.day     = 5'($urandom_range(25, 31));
        t.weekday = 3'd7;
        t.hour    = 5'($urandom_range(0, 2));
        t.minute  = 6'($urandom_range(10, 59));
        t.dst     = ($urandom_range(0, 3) != 0);
      end
      default: begin
        t.year    = 16'($urandom);
        t.month   = 4'($urandom);
        t.day     = 5'($urandom);
        t.hour    = 5'($urandom);
        t.minute  = 6'($urandom);
        t.weekday = 3'($urandom);
        t.dst     = 1'($urandom);
      end
    endcase
    return t;
  endfunction

  task automatic test_random_calendar();
    int unsigned sent;
    int unsigned run_len;
    start_kind_t kind;
    sent = 0;
    while (sent < RANDOM_BEATS) begin
      drain_results();
      kind = start_kind_t'($urandom_range(0, 6));
      if (kind == START_ONE_REG) begin
        // one write to a random index reloads from all start registers unless the index is unused
        cfg_write(3'($urandom_range(0, 7)), 16'($urandom));
        cfg_we <= 1'b0;
      end else begin
        load_clock(pick_start(kind), ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'h0000);
      end
      sender_gappy = ($urandom_range(0, 2) != 0);
      run_len = $urandom_range(10, 80);
      repeat (run_len) send_tick($urandom_range(0, 7) != 0);
      sent += run_len;
    end
    drain_results();
  endtask

  task automatic test_sink_hold();
    load_clock(pick_start(START_MONTH_END), 16'h0000);
    sender_gappy = 1'b0;
    hold_len = 400;
    hold_request = 1'b1;
    while (!sink_holding) @(posedge clk);
    // keep offering while the sink is shut so the block backs up
    repeat (30) send_tick(1'b1);
    // pause until every result is back, then carry on
    drain_results();
    repeat (20) send_tick($urandom_range(0, 3) != 0);
    drain_results();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_index     <= ccd_pkg::CFG_START_YEAR;
    cfg_data      <= '0;
    tick_ch.valid <= 1'b0;
    tick_ch.tick  <= 1'b0;
    start_regs = ccd_pkg::START_RST;
    wall_now   = start_regs;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_values();
    test_field_extremes();
    test_leap_years();
    test_summer_time();
    test_random_calendar();
    test_sink_hold();

    drain_results();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
